FILE: rtl/dgts_pkg.sv
// Shared types and constants for the density grid trilinear sampler.
`default_nettype none
package dgts_pkg;
    localparam int DEF_SIZE_X = 16;
    localparam int DEF_SIZE_Y = 16;
    localparam int DEF_SIZE_Z = 16;
    localparam int DEN_W      = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORG_X   = 3'd0,
        CFG_ORG_Y   = 3'd1,
        CFG_ORG_Z   = 3'd2,
        CFG_ISO     = 3'd3,
        CFG_INV_SFT = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_SAMP,
        ST_DONE
    } t_state;

    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/density_grid_trilinear_sampler_top.sv
// Top level: density grid store, column loader and trilinear sampler.
//
// Usage:
//   Input words arrive on s_axis_*. tuser is the kind: 0 loads a column,
//   1 samples a position. tlast marks the final column; once seen the grid
//   is valid until reset. Column words produce no output word.
//   Each sample word produces one output word on m_axis_*: tdata carries
//   the interpolated Q.8 density, tuser the in-range flag.
//   Configuration (origins, iso level, softness reciprocal) is written via
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   A column issues SIZE_Y+1 lattice levels, one per cycle, into the soft
//   threshold unit. The single memory write port, one lattice level per
//   cycle, sets this rate.
//   A sample reads its 8 corners, one corner per cycle on the read port,
//   then weights and sums them in the multiply/accumulate stages; a sample
//   out of range, or before the grid is valid, goes straight to the output.
// Reset: synchronous, active low; clears control state and grid-valid.
//   The grid memory is not cleared and needs no sweep.
// Stall: the output register holds a word until taken; the next input word
//   is accepted meanwhile, and a finished sample waits only if the output
//   register is still full.
`default_nettype none
module density_grid_trilinear_sampler_top #(
    parameter int SIZE_X = dgts_pkg::DEF_SIZE_X,
    parameter int SIZE_Y = dgts_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z = dgts_pkg::DEF_SIZE_Z
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // column_x[4:0], column_z[9:5], surface_height[33:10], pos_x[57:34],
    // pos_y[81:58], pos_z[105:82], zero fill [111:106]
    input  wire logic [dgts_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // kind
    input  wire logic                                  s_axis_tuser,
    // last_column
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // density[23:0]
    output logic [dgts_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
    // in_range
    output logic                                       m_axis_tuser,
    input  wire logic                                  i_cfg_we,
    input  wire logic [dgts_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [dgts_pkg::CFG_W-1:0]            i_cfg_data
);
    import dgts_pkg::*;

    localparam int LX    = SIZE_X + 1;
    localparam int LY    = SIZE_Y + 1;
    localparam int LZ    = SIZE_Z + 1;
    localparam int DEPTH = LX * LY * LZ;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(LX);
    localparam int YW    = $clog2(LY);
    localparam int ZW    = $clog2(LZ);
    localparam int YCW   = $clog2(LY + 1);

    // ---------------- configuration registers
    logic signed [CFG_W-1:0] r_org_x, r_org_y, r_org_z, r_iso;
    logic [CFG_W-1:0]        r_inv_soft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_org_z    <= '0;
            r_iso      <= 16'sd13;
            r_inv_soft <= 16'd427;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORG_X:   r_org_x    <= i_cfg_data;
                CFG_ORG_Y:   r_org_y    <= i_cfg_data;
                CFG_ORG_Z:   r_org_z    <= i_cfg_data;
                CFG_ISO:     r_iso      <= i_cfg_data;
                CFG_INV_SFT: r_inv_soft <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input field split
    logic [4:0]              w_cx, w_cz;
    logic signed [DEN_W-1:0] w_h, w_px, w_py, w_pz;
    assign w_cx = s_axis_tdata[4:0];
    assign w_cz = s_axis_tdata[9:5];
    assign w_h  = s_axis_tdata[33:10];
    assign w_px = s_axis_tdata[57:34];
    assign w_py = s_axis_tdata[81:58];
    assign w_pz = s_axis_tdata[105:82];

    // local = pos - origin*256; inside when 0 <= local < (size+1)*256
    function automatic logic locate_ok(input logic signed [DEN_W-1:0] pos,
                                       input logic signed [CFG_W-1:0] org,
                                       input int size);
        logic signed [24:0] loc;
        loc = 25'(pos) - 25'($signed({org, 8'd0}));
        return !loc[24] && (32'(loc) < 32'((size + 1) * 256));
    endfunction

    function automatic logic [24:0] local_of(input logic signed [DEN_W-1:0] pos,
                                             input logic signed [CFG_W-1:0] org);
        return 25'(pos) - 25'($signed({org, 8'd0}));
    endfunction

    logic [24:0] w_lx, w_ly, w_lz;
    logic        w_in;
    assign w_lx = local_of(w_px, r_org_x);
    assign w_ly = local_of(w_py, r_org_y);
    assign w_lz = local_of(w_pz, r_org_z);
    assign w_in = locate_ok(w_px, r_org_x, SIZE_X) && locate_ok(w_py, r_org_y, SIZE_Y)
               && locate_ok(w_pz, r_org_z, SIZE_Z);

    logic [XW-1:0] w_x0, w_x1;
    logic [YW-1:0] w_y0, w_y1;
    logic [ZW-1:0] w_z0, w_z1;
    always_comb begin
        w_x0 = w_lx[8 +: XW];
        w_y0 = w_ly[8 +: YW];
        w_z0 = w_lz[8 +: ZW];
        w_x1 = (32'(w_x0) >= 32'(SIZE_X)) ? XW'(SIZE_X) : w_x0 + XW'(1);
        w_y1 = (32'(w_y0) >= 32'(SIZE_Y)) ? YW'(SIZE_Y) : w_y0 + YW'(1);
        w_z1 = (32'(w_z0) >= 32'(SIZE_Z)) ? ZW'(SIZE_Z) : w_z0 + ZW'(1);
    end

    // ---------------- control
    t_state r_state, n_state;
    logic   r_grid_valid;
    logic signed [DEN_W-1:0] r_h;
    logic [4:0]     r_cx, r_cz;
    logic [YCW-1:0] r_ycnt;
    logic [XW-1:0]  r_x0, r_x1;
    logic [YW-1:0]  r_y0, r_y1;
    logic [ZW-1:0]  r_z0, r_z1;
    logic [7:0]     r_fx, r_fy, r_fz;
    logic           r_ok;
    logic [3:0]     r_corner;

    logic w_in_acc, w_out_acc, w_load_out, w_col_issue, w_samp_issue, w_samp_idle;
    logic w_soft_busy, w_wr_v;
    logic [AW-1:0]  w_wr_addr, w_col_addr, w_rd_addr;
    logic signed [DEN_W-1:0] w_wr_data;

    // sample pipeline
    logic           r_p1_v, r_p2_v, r_p3_v;
    logic           r_p1_xb;
    logic [16:0]    r_wyz;
    logic signed [DEN_W-1:0] r_rd, r_rd2;
    logic [24:0]    r_w;
    logic signed [48:0] r_prod;
    logic signed [49:0] r_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign w_col_issue   = (r_state == ST_COL) && (32'(r_ycnt) < 32'(LY));
    assign w_samp_issue  = (r_state == ST_SAMP) && !r_corner[3];
    assign w_samp_idle   = r_corner[3] && !r_p1_v && !r_p2_v && !r_p3_v;
    assign w_load_out    = (r_state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == KIND_SAMPLE) begin
                        n_state = (r_grid_valid && w_in) ? ST_SAMP : ST_DONE;
                    end else if (32'(w_cx) <= 32'(SIZE_X) && 32'(w_cz) <= 32'(SIZE_Z)) begin
                        n_state = ST_COL;
                    end
                end
            end
            ST_COL: begin
                if (!w_col_issue && !w_soft_busy) n_state = ST_IDLE;
            end
            ST_SAMP: begin
                if (w_samp_idle) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_grid_valid <= 1'b0;
            r_ycnt       <= '0;
            r_corner     <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && s_axis_tuser == KIND_COLUMN && s_axis_tlast) begin
                r_grid_valid <= 1'b1;
            end
            if (w_in_acc) begin
                r_ycnt   <= '0;
                r_corner <= '0;
            end else begin
                if (w_col_issue)  r_ycnt   <= r_ycnt + YCW'(1);
                if (w_samp_issue) r_corner <= r_corner + 4'd1;
            end
        end
        if (w_in_acc) begin
            r_h  <= w_h;
            r_cx <= w_cx;
            r_cz <= w_cz;
            r_x0 <= w_x0;
            r_x1 <= w_x1;
            r_y0 <= w_y0;
            r_y1 <= w_y1;
            r_z0 <= w_z0;
            r_z1 <= w_z1;
            r_fx <= w_lx[7:0];
            r_fy <= w_ly[7:0];
            r_fz <= w_lz[7:0];
            r_ok <= r_grid_valid && w_in;
        end
    end

    // ---------------- column loader
    assign w_col_addr = AW'((AW'(r_ycnt) * AW'(LZ) + AW'(r_cz)) * AW'(LX) + AW'(r_cx));

    dgts_soft #(
        .AW(AW)
    ) u_soft (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_col_issue),
        .i_addr     (w_col_addr),
        .i_height   (r_h),
        .i_y_world  (17'(r_org_y) + 17'(r_ycnt)),
        .i_iso      (r_iso),
        .i_inv_soft (r_inv_soft),
        .o_valid    (w_wr_v),
        .o_addr     (w_wr_addr),
        .o_data     (w_wr_data),
        .o_busy     (w_soft_busy)
    );

    // ---------------- grid memory, one write and one read port
    logic [DEN_W-1:0] r_mem [DEPTH];

    logic [XW-1:0] w_cxs;
    logic [YW-1:0] w_cys;
    logic [ZW-1:0] w_czs;
    assign w_cxs     = r_corner[0] ? r_x1 : r_x0;
    assign w_cys     = r_corner[1] ? r_y1 : r_y0;
    assign w_czs     = r_corner[2] ? r_z1 : r_z0;
    assign w_rd_addr = AW'((AW'(w_cys) * AW'(LZ) + AW'(w_czs)) * AW'(LX) + AW'(w_cxs));

    always_ff @(posedge i_clk) begin
        if (w_wr_v) r_mem[w_wr_addr] <= w_wr_data;
        if (w_samp_issue) r_rd <= r_mem[w_rd_addr];
    end

    // ---------------- weight and accumulate pipeline
    logic [8:0] w_wy, w_wz, w_wx;
    assign w_wy = r_corner[1] ? 9'(r_fy) : 9'd256 - 9'(r_fy);
    assign w_wz = r_corner[2] ? 9'(r_fz) : 9'd256 - 9'(r_fz);
    assign w_wx = r_p1_xb ? 9'(r_fx) : 9'd256 - 9'(r_fx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= w_samp_issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
        r_wyz   <= 17'(w_wy) * 17'(w_wz);
        r_p1_xb <= r_corner[0];
        r_w     <= 25'(r_wyz) * 25'(w_wx);
        r_rd2   <= r_rd;
        r_prod  <= 49'(r_rd2) * $signed({24'd0, r_w});
        if (w_in_acc)    r_acc <= '0;
        else if (r_p3_v) r_acc <= r_acc + 50'(r_prod);
    end

    // ---------------- round to Q.8, ties away from zero, saturate
    logic [49:0] w_amag;
    logic [25:0] w_rm;
    logic signed [DEN_W-1:0] w_res;
    always_comb begin
        w_amag = r_acc[49] ? 50'(-r_acc) : 50'(r_acc);
        w_rm   = 26'((w_amag + 50'd8388608) >> 24);
        if (r_acc[49]) begin
            w_res = (w_rm > 26'd8388608) ? -24'sd8388608 : DEN_W'(-$signed({1'b0, w_rm}));
        end else begin
            w_res = (w_rm > 26'd8388607) ? 24'sd8388607 : DEN_W'(w_rm);
        end
    end

    // ---------------- output register
    logic r_out_v, r_out_rng;
    logic [DEN_W-1:0] r_out_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load_out) begin
            r_out_v <= 1'b1;
        end else if (w_out_acc) begin
            r_out_v <= 1'b0;
        end
        if (w_load_out) begin
            r_out_den <= r_ok ? w_res : '0;
            r_out_rng <= r_ok;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_den;
    assign m_axis_tuser  = r_out_rng;

    // ---------------- checks
    a_no_wr_in_samp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAMP) |-> !w_wr_v)
        else $error("grid write during sample");
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_grid_valid) |-> r_grid_valid)
        else $error("grid valid dropped");
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("nonzero density out of range");
    a_acc_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p3_v |-> (r_state == ST_SAMP))
        else $error("accumulate outside sample");
endmodule
`default_nettype wire

FILE: rtl/dgts_soft.sv
// Three-stage soft-threshold density pipeline for column loads.
`default_nettype none
module dgts_soft #(
    parameter int AW = 13
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [AW-1:0]                      i_addr,
    input  wire logic signed [dgts_pkg::DEN_W-1:0]  i_height,
    input  wire logic signed [16:0]                 i_y_world,
    input  wire logic signed [dgts_pkg::CFG_W-1:0]  i_iso,
    input  wire logic [dgts_pkg::CFG_W-1:0]         i_inv_soft,
    output logic                                    o_valid,
    output logic [AW-1:0]                           o_addr,
    output logic signed [dgts_pkg::DEN_W-1:0]       o_data,
    output logic                                    o_busy
);
    import dgts_pkg::*;

    logic signed [25:0] w_d;
    logic [24:0]        w_mag;
    logic [8:0]         w_k;
    logic [34:0]        w_sum;
    logic [25:0]        w_s;
    logic signed [DEN_W-1:0] w_sat;

    logic               r_v1, r_v2, r_v3;
    logic [AW-1:0]      r_a1, r_a2, r_a3;
    logic [24:0]        r_mag1, r_mag2;
    logic               r_neg1, r_neg2;
    logic [40:0]        r_prod;
    logic signed [DEN_W-1:0] r_data;

    always_comb begin
        w_d   = 26'(i_height) - 26'($signed({i_y_world, 8'd0})) - 26'(i_iso);
        w_mag = w_d[25] ? 25'(-w_d) : w_d[24:0];
        w_k   = (r_prod[40:8] > 33'd256) ? 9'd256 : r_prod[16:8];
        w_sum = 35'(r_mag2) * 35'(10'd256 + 10'(w_k)) + 35'd256;
        w_s   = w_sum[34:9];
        if (r_neg2) begin
            w_sat = (w_s > 26'd8388608) ? -24'sd8388608 : DEN_W'(-$signed({1'b0, w_s}));
        end else begin
            w_sat = (w_s > 26'd8388607) ? 24'sd8388607 : DEN_W'(w_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_a1   <= i_addr;
        r_mag1 <= w_mag;
        r_neg1 <= w_d[25];
        r_a2   <= r_a1;
        r_mag2 <= r_mag1;
        r_neg2 <= r_neg1;
        r_prod <= 41'(r_mag1) * 41'(i_inv_soft);
        r_a3   <= r_a2;
        r_data <= w_sat;
    end

    assign o_valid = r_v3;
    assign o_addr  = r_a3;
    assign o_data  = r_data;
    assign o_busy  = r_v1 | r_v2 | r_v3;
endmodule
`default_nettype wire
